// ----- hw/rtl/polyline_simplifier_top_macros.svh -----
// Assertion macros for the polyline simplifier
`ifndef POLYLINE_SIMPLIFIER_TOP_MACROS_SVH
`define POLYLINE_SIMPLIFIER_TOP_MACROS_SVH
`ifndef SYNTH
`define PLS_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
`define PLS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define PLS_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg)
`define PLS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/plsimp_pkg.sv -----
`default_nettype none
package plsimp_pkg;

  localparam int TOLW = 23;
  localparam logic [TOLW-1:0] TOL_RESET = 23'd51;
  localparam int DIGW = 16;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_START,
    ST_MUL,
    ST_INIT,
    ST_POP,
    ST_SEG,
    ST_GS,
    ST_GE,
    ST_LEN,
    ST_PRD,
    ST_PGET,
    ST_PST,
    ST_CMP,
    ST_DEC,
    ST_PU1,
    ST_PU2,
    ST_ERD,
    ST_ECHK,
    ST_EMPTY
  } state_t;

  typedef enum logic [3:0] {
    OP_EPS,
    OP_DXX,
    OP_DYY,
    OP_THR,
    OP_PXX,
    OP_PYY,
    OP_C1,
    OP_C2,
    OP_CC
  } mul_op_t;

endpackage
`default_nettype wire

// ----- hw/rtl/plsimp_point_if.sv -----
`default_nettype none
interface plsimp_point_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         point_last;

  modport source(output valid, point_x, point_y, point_last, input ready);
  modport sink(input valid, point_x, point_y, point_last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/plsimp_kept_if.sv -----
`default_nettype none
interface plsimp_kept_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] kept_x;
  logic signed [COORD_BITS-1:0] kept_y;
  logic                         kept_last;
  logic                         empty_path;
  logic                         overflowed;

  modport source(output valid, kept_x, kept_y, kept_last, empty_path, overflowed,
                 input ready);
  modport sink(input valid, kept_x, kept_y, kept_last, empty_path, overflowed,
               output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/plsimp_mul.sv -----
`default_nettype none
module plsimp_mul #(
  parameter int MW = 51
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [MW-1:0]   a,
  input  wire logic [MW-1:0]   b,
  output logic                 done,
  output logic [2*MW-1:0]      prod
);

  localparam int PW   = 2 * MW;
  localparam int DW   = plsimp_pkg::DIGW;
  localparam int NDIG = (MW + DW - 1) / DW;
  localparam int BW   = NDIG * DW;
  localparam int CW   = $clog2(NDIG + 1);

  logic [MW-1:0]    a_r;
  logic [BW-1:0]    b_r;
  logic [PW-1:0]    acc;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [MW+DW-1:0] pp;

  // MSB digit first: acc = acc * 2^DW + a * digit
  assign pp   = MW'(a_r) * b_r[BW-1 -: DW];
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= BW'(b);
      acc <= '0;
      cnt <= CW'(NDIG);
    end else if (busy) begin
      acc <= (acc << DW) + PW'(pp);
      b_r <= b_r << DW;
      cnt <= cnt - CW'(1);
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/polyline_simplifier_top.sv -----
// Loading: one point per cycle. Output: kept points one at a time, each held until kept.ready.
// Simplify: each multiply steps through NDIG = ceil(MW/16) digits (4 at defaults);
// one multiply starts a path, three serve each segment and three each interior
// point; a degenerate chord saves one multiply per segment and per point.
// One path in work at a time.
// Reset (synchronous): path cleared, tolerance 51; point memory not cleared.
`default_nettype none
`include "polyline_simplifier_top_macros.svh"
module polyline_simplifier_top #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [plsimp_pkg::TOLW-1:0] cfg_wdata,
  plsimp_point_if.sink                     points,
  plsimp_kept_if.source                    kept
);

  localparam int TW   = plsimp_pkg::TOLW;
  localparam int CW   = COORD_BITS;
  localparam int DW   = CW + 1;
  localparam int MWA  = 2 * DW + 1;
  localparam int MW   = (MWA > 2 * TW) ? MWA : 2 * TW;
  localparam int PW   = 2 * MW;
  localparam int IW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNTW = $clog2(MAX_POINTS + 1);

  plsimp_pkg::state_t  state, state_next;
  plsimp_pkg::mul_op_t op;

  logic [TW-1:0]         tolerance;
  logic [CNTW-1:0]       count;
  logic [CNTW-1:0]       depth;
  logic                  drop;

  // entry: {x, y, keep mark}
  logic [2*CW:0]   pt_mem [MAX_POINTS];
  logic [2*CW:0]   pt_rd;
  logic            pt_we, pt_rd_en;
  logic [IW-1:0]   pt_wa, pt_ra;
  logic            mk_we;

  logic [2*IW-1:0] stk_mem [MAX_POINTS];
  logic [2*IW-1:0] stk_rd;
  logic            stk_we, stk_rd_en;
  logic [IW-1:0]   stk_wa, stk_ra;
  logic [2*IW-1:0] stk_wd;

  logic [IW-1:0] s, e, i, best;
  logic signed [CW-1:0] ps_x, ps_y;
  logic signed [DW-1:0] dx, dy, px, py;
  logic signed [MW-1:0] p1;
  logic [PW-1:0] eps2, len2, thr, d, dmax;
  logic          deg;

  logic          mul_start, mul_done;
  logic [MW-1:0] mul_a, mul_b;
  logic [PW-1:0] mul_prod;

  logic          ov;
  logic          out_free;
  logic          accept;
  logic          last_emit;

  logic signed [CW-1:0] rd_x, rd_y;
  logic                 rd_mk;
  logic                 keep_pt;
  logic                 best_ok;
  logic [PW-1:0]        len2_sum;
  logic [PW-1:0]        d_sum;
  logic signed [MW-1:0] sp;
  logic signed [MW-1:0] cr;
  logic                 split;
  logic                 push1, push2;

  function automatic logic [MW-1:0] mag(input logic signed [DW-1:0] v);
    logic [DW-1:0] u;
    u = v[DW-1] ? DW'(-v) : DW'(v);
    return MW'(u);
  endfunction

  function automatic logic [MW-1:0] magw(input logic signed [MW-1:0] v);
    return v[MW-1] ? MW'(-v) : MW'(v);
  endfunction

  assign rd_x      = pt_rd[2*CW:CW+1];
  assign rd_y      = pt_rd[CW:1];
  assign rd_mk     = pt_rd[0];
  assign accept    = points.valid && points.ready;
  assign out_free  = !ov || kept.ready;
  assign len2_sum  = len2 + mul_prod;
  assign d_sum     = d + mul_prod;
  assign split     = (best != '0) && (dmax > thr);
  assign last_emit = (CNTW'(i) == count - CNTW'(1));
  // first and last stored points are always kept
  assign keep_pt   = rd_mk || (i == '0) || last_emit;
  assign best_ok   = (best == '0) || ((best > s) && (best < e));
  assign push1     = ({1'b0, e} >= {1'b0, best} + (IW+1)'(2)) &&
                     (depth < CNTW'(MAX_POINTS));
  assign push2     = ({1'b0, best} >= {1'b0, s} + (IW+1)'(2)) &&
                     (depth < CNTW'(MAX_POINTS));

  // signed product of the pending cross term
  always_comb begin
    logic neg;
    neg = 1'b0;
    if (op == plsimp_pkg::OP_C1) begin
      neg = dx[DW-1] ^ py[DW-1];
    end else begin
      neg = dy[DW-1] ^ px[DW-1];
    end
    sp = neg ? -$signed(mul_prod[MW-1:0]) : $signed(mul_prod[MW-1:0]);
    cr = p1 - sp;
  end

  plsimp_mul #(.MW(MW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_wa] <= {points.point_x, points.point_y, 1'b0};
    end
    if (mk_we) begin
      pt_mem[best][0] <= 1'b1;
    end
    if (pt_rd_en) begin
      pt_rd <= pt_mem[pt_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (stk_rd_en) begin
      stk_rd <= stk_mem[stk_ra];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      plsimp_pkg::ST_LOAD: begin
        if (accept && points.point_last) state_next = plsimp_pkg::ST_START;
      end
      plsimp_pkg::ST_START: begin
        state_next = (count < CNTW'(2)) ? plsimp_pkg::ST_EMPTY : plsimp_pkg::ST_MUL;
      end
      plsimp_pkg::ST_MUL: begin
        if (mul_done) begin
          case (op)
            plsimp_pkg::OP_EPS: state_next = plsimp_pkg::ST_INIT;
            plsimp_pkg::OP_DYY: begin
              if (len2_sum == '0) state_next = plsimp_pkg::ST_PRD;
            end
            plsimp_pkg::OP_THR: state_next = plsimp_pkg::ST_PRD;
            plsimp_pkg::OP_PYY, plsimp_pkg::OP_CC: state_next = plsimp_pkg::ST_CMP;
            default: state_next = plsimp_pkg::ST_MUL;
          endcase
        end
      end
      plsimp_pkg::ST_INIT: state_next = plsimp_pkg::ST_POP;
      plsimp_pkg::ST_POP: begin
        state_next = (depth == '0) ? plsimp_pkg::ST_ERD : plsimp_pkg::ST_SEG;
      end
      plsimp_pkg::ST_SEG:  state_next = plsimp_pkg::ST_GS;
      plsimp_pkg::ST_GS:   state_next = plsimp_pkg::ST_GE;
      plsimp_pkg::ST_GE:   state_next = plsimp_pkg::ST_LEN;
      plsimp_pkg::ST_LEN:  state_next = plsimp_pkg::ST_MUL;
      plsimp_pkg::ST_PRD: begin
        state_next = (i == e) ? plsimp_pkg::ST_DEC : plsimp_pkg::ST_PGET;
      end
      plsimp_pkg::ST_PGET: state_next = plsimp_pkg::ST_PST;
      plsimp_pkg::ST_PST:  state_next = plsimp_pkg::ST_MUL;
      plsimp_pkg::ST_CMP:  state_next = plsimp_pkg::ST_PRD;
      plsimp_pkg::ST_DEC: begin
        state_next = split ? plsimp_pkg::ST_PU1 : plsimp_pkg::ST_POP;
      end
      plsimp_pkg::ST_PU1:  state_next = plsimp_pkg::ST_PU2;
      plsimp_pkg::ST_PU2:  state_next = plsimp_pkg::ST_POP;
      plsimp_pkg::ST_ERD:  state_next = plsimp_pkg::ST_ECHK;
      plsimp_pkg::ST_ECHK: begin
        if (!keep_pt) begin
          state_next = plsimp_pkg::ST_ERD;
        end else if (out_free) begin
          state_next = last_emit ? plsimp_pkg::ST_LOAD : plsimp_pkg::ST_ERD;
        end
      end
      plsimp_pkg::ST_EMPTY: begin
        if (out_free) state_next = plsimp_pkg::ST_LOAD;
      end
      default: state_next = plsimp_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    points.ready = 1'b0;
    pt_we        = 1'b0;
    pt_wa        = count[IW-1:0];
    pt_rd_en     = 1'b0;
    pt_ra        = i;
    mk_we        = 1'b0;
    stk_we       = 1'b0;
    stk_wa       = depth[IW-1:0];
    stk_wd       = {best, e};
    stk_rd_en    = 1'b0;
    stk_ra       = IW'(depth - CNTW'(1));
    unique case (state)
      plsimp_pkg::ST_LOAD: begin
        points.ready = 1'b1;
        pt_we        = accept && (count < CNTW'(MAX_POINTS));
      end
      plsimp_pkg::ST_INIT: begin
        stk_we = (count >= CNTW'(3));
        stk_wd = {IW'(0), IW'(count - CNTW'(1))};
      end
      plsimp_pkg::ST_POP: stk_rd_en = (depth != '0);
      plsimp_pkg::ST_SEG: begin
        pt_rd_en = 1'b1;
        pt_ra    = stk_rd[2*IW-1:IW];
      end
      plsimp_pkg::ST_GS: begin
        pt_rd_en = 1'b1;
        pt_ra    = e;
      end
      plsimp_pkg::ST_PRD: pt_rd_en = (i != e);
      plsimp_pkg::ST_DEC: mk_we = split;
      plsimp_pkg::ST_PU1: stk_we = push1;
      plsimp_pkg::ST_PU2: begin
        stk_we = push2;
        stk_wd = {s, best};
      end
      plsimp_pkg::ST_ERD: pt_rd_en = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= plsimp_pkg::ST_LOAD;
      tolerance <= plsimp_pkg::TOL_RESET;
      count     <= '0;
      depth     <= '0;
      drop      <= 1'b0;
      ov        <= 1'b0;
      mul_start <= 1'b0;
      op        <= plsimp_pkg::OP_EPS;
    end else begin
      state     <= state_next;
      mul_start <= 1'b0;
      if (cfg_we) tolerance <= cfg_wdata;
      if (kept.ready) ov <= 1'b0;
      if (stk_we) depth <= depth + CNTW'(1);
      case (state)
        plsimp_pkg::ST_LOAD: begin
          if (accept) begin
            if (count < CNTW'(MAX_POINTS)) count <= count + CNTW'(1);
            else drop <= 1'b1;
          end
        end
        plsimp_pkg::ST_START: begin
          if (count >= CNTW'(2)) begin
            mul_start <= 1'b1;
            op        <= plsimp_pkg::OP_EPS;
          end
        end
        plsimp_pkg::ST_POP: begin
          if (depth != '0) depth <= depth - CNTW'(1);
        end
        plsimp_pkg::ST_LEN: begin
          mul_start <= 1'b1;
          op        <= plsimp_pkg::OP_DXX;
        end
        plsimp_pkg::ST_PST: begin
          mul_start <= 1'b1;
          op        <= deg ? plsimp_pkg::OP_PXX : plsimp_pkg::OP_C1;
        end
        plsimp_pkg::ST_MUL: begin
          if (mul_done) begin
            case (op)
              plsimp_pkg::OP_DXX: begin
                mul_start <= 1'b1;
                op        <= plsimp_pkg::OP_DYY;
              end
              plsimp_pkg::OP_DYY: begin
                if (len2_sum != '0) begin
                  mul_start <= 1'b1;
                  op        <= plsimp_pkg::OP_THR;
                end
              end
              plsimp_pkg::OP_PXX: begin
                mul_start <= 1'b1;
                op        <= plsimp_pkg::OP_PYY;
              end
              plsimp_pkg::OP_C1: begin
                mul_start <= 1'b1;
                op        <= plsimp_pkg::OP_C2;
              end
              plsimp_pkg::OP_C2: begin
                mul_start <= 1'b1;
                op        <= plsimp_pkg::OP_CC;
              end
              default: begin
              end
            endcase
          end
        end
        plsimp_pkg::ST_ECHK: begin
          if (keep_pt && out_free) begin
            ov <= 1'b1;
            if (last_emit) begin
              count <= '0;
              drop  <= 1'b0;
            end
          end
        end
        plsimp_pkg::ST_EMPTY: begin
          if (out_free) begin
            ov    <= 1'b1;
            count <= '0;
            drop  <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      plsimp_pkg::ST_START: begin
        mul_a <= MW'(tolerance);
        mul_b <= MW'(tolerance);
      end
      plsimp_pkg::ST_POP: begin
        i <= '0;
      end
      plsimp_pkg::ST_SEG: begin
        s <= stk_rd[2*IW-1:IW];
        e <= stk_rd[IW-1:0];
      end
      plsimp_pkg::ST_GS: begin
        ps_x <= rd_x;
        ps_y <= rd_y;
      end
      plsimp_pkg::ST_GE: begin
        dx   <= $signed({rd_x[CW-1], rd_x}) - $signed({ps_x[CW-1], ps_x});
        dy   <= $signed({rd_y[CW-1], rd_y}) - $signed({ps_y[CW-1], ps_y});
        i    <= s + IW'(1);
        dmax <= '0;
        best <= '0;
        deg  <= 1'b0;
      end
      plsimp_pkg::ST_LEN: begin
        mul_a <= mag(dx);
        mul_b <= mag(dx);
      end
      plsimp_pkg::ST_PGET: begin
        px <= $signed({rd_x[CW-1], rd_x}) - $signed({ps_x[CW-1], ps_x});
        py <= $signed({rd_y[CW-1], rd_y}) - $signed({ps_y[CW-1], ps_y});
      end
      plsimp_pkg::ST_PST: begin
        mul_a <= deg ? mag(px) : mag(dx);
        mul_b <= deg ? mag(px) : mag(py);
      end
      plsimp_pkg::ST_MUL: begin
        if (mul_done) begin
          case (op)
            plsimp_pkg::OP_EPS: eps2 <= mul_prod;
            plsimp_pkg::OP_DXX: begin
              len2  <= mul_prod;
              mul_a <= mag(dy);
              mul_b <= mag(dy);
            end
            plsimp_pkg::OP_DYY: begin
              len2  <= len2_sum;
              deg   <= (len2_sum == '0);
              thr   <= eps2;
              mul_a <= eps2[MW-1:0];
              mul_b <= len2_sum[MW-1:0];
            end
            plsimp_pkg::OP_THR: thr <= mul_prod;
            plsimp_pkg::OP_PXX: begin
              d     <= mul_prod;
              mul_a <= mag(py);
              mul_b <= mag(py);
            end
            plsimp_pkg::OP_PYY: d <= d_sum;
            plsimp_pkg::OP_C1: begin
              p1    <= sp;
              mul_a <= mag(dy);
              mul_b <= mag(px);
            end
            plsimp_pkg::OP_C2: begin
              mul_a <= magw(cr);
              mul_b <= magw(cr);
            end
            plsimp_pkg::OP_CC: d <= mul_prod;
            default: begin
            end
          endcase
        end
      end
      plsimp_pkg::ST_CMP: begin
        if (d > dmax) begin
          dmax <= d;
          best <= i;
        end
        i <= i + IW'(1);
      end
      plsimp_pkg::ST_ECHK: begin
        if (!keep_pt || (out_free && !last_emit)) i <= i + IW'(1);
        if (keep_pt && out_free) begin
          kept.kept_x     <= rd_x;
          kept.kept_y     <= rd_y;
          kept.kept_last  <= last_emit;
          kept.empty_path <= 1'b0;
          kept.overflowed <= drop;
        end
      end
      plsimp_pkg::ST_EMPTY: begin
        if (out_free) begin
          kept.kept_x     <= '0;
          kept.kept_y     <= '0;
          kept.kept_last  <= 1'b1;
          kept.empty_path <= 1'b1;
          kept.overflowed <= drop;
        end
      end
      default: begin
      end
    endcase
  end

  assign kept.valid = ov;

  `PLS_ASSERT_IMPL(a_ready_stack_empty, clk, rst, points.ready, depth == '0, "stack busy")
  `PLS_ASSERT_IMPL(a_count_range, clk, rst, 1'b1, count <= CNTW'(MAX_POINTS), "count range")
  `PLS_ASSERT_IMPL(a_best_interior, clk, rst, state == plsimp_pkg::ST_DEC, best_ok, "best")
  `PLS_ASSERT_NEXT(a_mul_no_early_done, clk, rst, mul_start, !mul_done, "early done")

endmodule
`default_nettype wire
